>>> rtl/dual_channel_frame_average_ema_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame averager
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_FRAME_AVERAGE_EMA_ASSERT_SVH
`define DUAL_CHANNEL_FRAME_AVERAGE_EMA_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCFA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold at a later cycle than the antecedent.
`define DCFA_ASSERT_TWO(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

>>> rtl/dcfa_pkg.sv
// ----------------------------------------------------------------------------
// dcfa_pkg
// Widths, limits, reset values and register indexes of the frame averager.
// ----------------------------------------------------------------------------
package dcfa_pkg;

	localparam int CHAN_W   = 4;
	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 24;
	localparam int VAL_W    = 20;
	localparam int WEIGHT_W = 17;
	localparam int CFG_IDX_W = 3;

	localparam logic [SUM_W-1:0]    SUM_MAX    = 24'hFFFFFF;
	localparam logic [VAL_W-1:0]    AVG_MAX    = 20'd1048320; // 4095.0 in 12.8
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = 17'd6554;
	localparam logic [CHAN_W-1:0]   ACT_CH_RST  = 4'd3;
	localparam logic [CHAN_W-1:0]   DES_CH_RST  = 4'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHT      = 3'd0,
		CFG_ACT_CHANNEL = 3'd1,
		CFG_DES_CHANNEL = 3'd2,
		CFG_OVR_ENABLE  = 3'd3,
		CFG_OVR_LEVEL   = 3'd4
	} cfg_index_t;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [VAL_W-1:0] val_t;

endpackage

>>> rtl/dcfa_blend.sv
// ----------------------------------------------------------------------------
// dcfa_blend
// Frame average and one exponential moving average update, 12.8 fixed point.
// ----------------------------------------------------------------------------
module dcfa_blend
	import dcfa_pkg::*;
#(
	parameter int SAMPLES_PER_CHANNEL = 64
) (
	input  sum_t                 frame_sum,
	input  val_t                 old_value,
	input  logic [WEIGHT_W-1:0]  weight,
	output val_t                 new_value
);

	// The user must keep the sample count a power of two, which the block does not enforce; the divide is a shift.
	localparam int SHIFT = $clog2(SAMPLES_PER_CHANNEL);

	logic [SUM_W+7:0]           scaled;
	val_t                       avg;
	logic [WEIGHT_W-1:0]        w_eff;
	logic signed [VAL_W:0]      diff;
	logic signed [VAL_W+WEIGHT_W+1:0] prod;
	logic signed [VAL_W+WEIGHT_W+1:0] rounded;
	logic signed [VAL_W+2:0]    step;
	logic signed [VAL_W+2:0]    total;

	// old*(1-w) + avg*w == old + (avg-old)*w, so one signed multiply does it
	always_comb begin
		scaled  = {frame_sum, 8'd0} >> SHIFT;
		avg     = (scaled > (SUM_W+8)'(AVG_MAX)) ? AVG_MAX : scaled[VAL_W-1:0];
		w_eff   = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
		diff    = $signed({1'b0, avg}) - $signed({1'b0, old_value});
		prod    = diff * $signed({1'b0, w_eff});
		rounded = prod + (VAL_W+WEIGHT_W+2)'(32768);
		step    = $signed(rounded[VAL_W+WEIGHT_W+1:16]);
		total   = $signed({3'b000, old_value}) + step;
		new_value = total[VAL_W-1:0];
	end

endmodule

>>> rtl/dual_channel_frame_average_ema.sv
// ----------------------------------------------------------------------------
// dual_channel_frame_average_ema
// Two-channel frame averager with exponential moving average smoothing.
// ----------------------------------------------------------------------------
// Takes one tagged converter sample per clock unless a closed frame waits on
// a stalled result. Samples on the actual channel (priority when both channel
// registers match) and on the desired channel are summed with saturation at
// 2^24-1; other channels are dropped. A sample with tlast set closes the
// frame: each sum is divided by SAMPLES_PER_CHANNEL (must be a power of two,
// 1 to 4096), clipped to 4095.0, blended into its smoothed value in 12.8
// fixed point, and both smoothed values come out as one result via the
// frame-total and output registers. The frame-end stage reads back the
// smoothed registers its multiplier feeds, so frames may be as short as one
// sample. The override forces the desired value and state to override_level.
// Register writes are taken every cycle and are meant for idle periods.
// ----------------------------------------------------------------------------
module dual_channel_frame_average_ema
	import dcfa_pkg::*;
#(
	parameter int SAMPLES_PER_CHANNEL = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // [11:0] sample_value
	input  logic                 s_axis_tlast,
	input  logic [CHAN_W-1:0]    s_axis_tuser,  // [3:0] sample_channel
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [2*VAL_W-1:0]   m_axis_tdata,  // [19:0] actual_filtered, [39:20] desired_filtered
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data
);

	logic [WEIGHT_W-1:0] weight_q;
	logic [CHAN_W-1:0]   act_channel_q;
	logic [CHAN_W-1:0]   des_channel_q;
	logic                ovr_enable_q;
	val_t                ovr_level_q;

	sum_t act_sum_q, des_sum_q;
	sum_t act_sum_next, des_sum_next;
	logic valid_s1;
	sum_t act_total_s1, des_total_s1;
	val_t act_smooth_q, des_smooth_q;
	val_t act_blend, des_blend;
	logic out_valid_q;
	val_t act_out_q, des_out_q;

	logic in_take, out_free, adv_s1;
	logic act_hit, des_hit;
	logic [SAMPLE_W-1:0] sample;
	logic [SUM_W:0] act_add, des_add;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q      <= WEIGHT_RST;
			act_channel_q <= ACT_CH_RST;
			des_channel_q <= DES_CH_RST;
			ovr_enable_q  <= 1'b0;
			ovr_level_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WEIGHT:      weight_q      <= cfg_data[WEIGHT_W-1:0];
				CFG_ACT_CHANNEL: act_channel_q <= cfg_data[CHAN_W-1:0];
				CFG_DES_CHANNEL: des_channel_q <= cfg_data[CHAN_W-1:0];
				CFG_OVR_ENABLE:  ovr_enable_q  <= cfg_data[0];
				CFG_OVR_LEVEL:   ovr_level_q   <= cfg_data;
				default:         ;
			endcase
		end
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// Accumulate the incoming sample, saturating
	always_comb begin
		sample  = s_axis_tdata[SAMPLE_W-1:0];
		act_hit = (s_axis_tuser == act_channel_q);
		des_hit = !act_hit && (s_axis_tuser == des_channel_q);
		act_add = {1'b0, act_sum_q} + (SUM_W+1)'(sample);
		des_add = {1'b0, des_sum_q} + (SUM_W+1)'(sample);
		act_sum_next = act_sum_q;
		des_sum_next = des_sum_q;
		if (act_hit) begin
			act_sum_next = act_add[SUM_W] ? SUM_MAX : act_add[SUM_W-1:0];
		end
		if (des_hit) begin
			des_sum_next = des_add[SUM_W] ? SUM_MAX : des_add[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_sum_q <= '0;
			des_sum_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (in_take) begin
				// clear the sums at frame end, hand the totals to the blend stage
				act_sum_q <= s_axis_tlast ? '0 : act_sum_next;
				des_sum_q <= s_axis_tlast ? '0 : des_sum_next;
			end
			if (in_take && s_axis_tlast) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && s_axis_tlast) begin
			act_total_s1 <= act_sum_next;
			des_total_s1 <= des_sum_next;
		end
	end

	dcfa_blend #(
		.SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
	) u_blend_act (
		.frame_sum (act_total_s1),
		.old_value (act_smooth_q),
		.weight    (weight_q),
		.new_value (act_blend)
	);

	dcfa_blend #(
		.SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
	) u_blend_des (
		.frame_sum (des_total_s1),
		.old_value (des_smooth_q),
		.weight    (weight_q),
		.new_value (des_blend)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_smooth_q <= '0;
			des_smooth_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (adv_s1) begin
				act_smooth_q <= act_blend;
				des_smooth_q <= ovr_enable_q ? ovr_level_q : des_blend;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			act_out_q <= act_blend;
			des_out_q <= ovr_enable_q ? ovr_level_q : des_blend;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {des_out_q, act_out_q};

endmodule

>>> rtl/dcfa_checker.sv
// ----------------------------------------------------------------------------
// dcfa_port_checks
// Port-level checks on the frame averager, bound to its top level.
// ----------------------------------------------------------------------------
`include "dual_channel_frame_average_ema_assert.svh"

module dcfa_port_checks
	import dcfa_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 s_axis_tlast,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [2*VAL_W-1:0]   m_axis_tdata
);

	logic fe_take;

	assign fe_take = s_axis_tvalid && s_axis_tready && s_axis_tlast;

	// A stalled result holds its payload
	`DCFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

	// With the output register empty, the input side is never stalled
	`DCFA_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

	// A frame end taken into an empty output shows a result once it has passed the frame-total and output registers
	`DCFA_ASSERT_TWO(a_frame_result, fe_take && !m_axis_tvalid, m_axis_tvalid, "frame end produced no result")

endmodule

bind dual_channel_frame_average_ema dcfa_port_checks u_dcfa_port_checks (.*);

>>> tb/sv/dcfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfa_checker
// Watches the sample, result and register channels of the frame averager,
// keeps its own copy of the sums, smoothed values and registers, predicts the
// filtered pair of every closed frame and compares it with what comes out.
// ----------------------------------------------------------------------------
module dcfa_checker
	import dcfa_pkg::*;
#(
	parameter int SAMPLES_PER_CHANNEL = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // [11:0] sample_value
	input  logic                 s_axis_tlast,
	input  logic [CHAN_W-1:0]    s_axis_tuser,  // [3:0] sample_channel
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [2*VAL_W-1:0]   m_axis_tdata,  // [19:0] actual_filtered, [39:20] desired_filtered
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	output int                   pending,
	output int                   fail_count
);

	typedef struct packed {
		val_t desired;
		val_t actual;
	} filtered_pair_t;

	filtered_pair_t filtered_q[$];

	logic [WEIGHT_W-1:0] weight;
	logic [CHAN_W-1:0]   act_ch;
	logic [CHAN_W-1:0]   des_ch;
	logic                ovr_en;
	val_t                ovr_level;

	sum_t act_sum;
	sum_t des_sum;
	val_t act_smooth;
	val_t des_smooth;

	function automatic sum_t sum_saturate(sum_t sum, logic [SAMPLE_W-1:0] v);
		logic [SUM_W:0] s;
		s = {1'b0, sum} + v;
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	function automatic val_t ema_blend(val_t old, sum_t sum, logic [WEIGHT_W-1:0] w_raw);
		logic [63:0] avg;
		logic [63:0] w;
		logic [63:0] acc;
		avg = {32'd0, sum, 8'd0};
		avg = avg / 64'(SAMPLES_PER_CHANNEL);
		if (avg > AVG_MAX)
			avg = 64'(AVG_MAX);
		// a weight above one acts as one
		w = 64'((w_raw > WEIGHT_ONE) ? WEIGHT_ONE : w_raw);
		acc = old * (64'(WEIGHT_ONE) - w) + avg * w + 64'd32768;
		return acc[VAL_W+15:16];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		filtered_pair_t want;
		filtered_pair_t got;
		logic [CHAN_W-1:0]   ch;
		logic [SAMPLE_W-1:0] val;
		if (!arst_n) begin
			weight     = WEIGHT_RST;
			act_ch     = ACT_CH_RST;
			des_ch     = DES_CH_RST;
			ovr_en     = 1'b0;
			ovr_level  = '0;
			act_sum    = '0;
			des_sum    = '0;
			act_smooth = '0;
			des_smooth = '0;
			filtered_q.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WEIGHT:      weight    = cfg_data[WEIGHT_W-1:0];
					CFG_ACT_CHANNEL: act_ch    = cfg_data[CHAN_W-1:0];
					CFG_DES_CHANNEL: des_ch    = cfg_data[CHAN_W-1:0];
					CFG_OVR_ENABLE:  ovr_en    = cfg_data[0];
					CFG_OVR_LEVEL:   ovr_level = cfg_data;
					default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (filtered_q.size() == 0) begin
					$error("unexpected result: actual_filtered got %0d, desired_filtered got %0d",
						got.actual, got.desired);
					fail_count++;
				end else begin
					want = filtered_q.pop_front();
					if (got.actual !== want.actual) begin
						$error("actual_filtered: expected %0d, got %0d", want.actual, got.actual);
						fail_count++;
					end
					if (got.desired !== want.desired) begin
						$error("desired_filtered: expected %0d, got %0d",
							want.desired, got.desired);
						fail_count++;
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				ch  = s_axis_tuser;
				val = s_axis_tdata[SAMPLE_W-1:0];
				// actual wins when both channel registers match
				if (ch == act_ch)
					act_sum = sum_saturate(act_sum, val);
				else if (ch == des_ch)
					des_sum = sum_saturate(des_sum, val);
				if (s_axis_tlast) begin
					act_smooth = ema_blend(act_smooth, act_sum, weight);
					des_smooth = ema_blend(des_smooth, des_sum, weight);
					if (ovr_en)
						des_smooth = ovr_level;
					act_sum = '0;
					des_sum = '0;
					want.actual  = act_smooth;
					want.desired = des_smooth;
					filtered_q.push_back(want);
				end
			end

			pending = filtered_q.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the frame averager: directed corner frames, then random phases
// of register settings and frames with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
	import dcfa_pkg::*;

	localparam int SAMPLES_PER_CHANNEL = 64;
	localparam int STALL_LIMIT         = 400;
	localparam int DRAIN_CYCLES        = 8;
	localparam int RANDOM_ITEMS        = 1300;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata  = '0;
	logic                 s_axis_tlast  = 1'b0;
	logic [CHAN_W-1:0]    s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [2*VAL_W-1:0]   m_axis_tdata;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [VAL_W-1:0]     cfg_data      = '0;

	int pending;
	int fail_count;
	int stall_cnt = 0;
	int n_samples = 0;
	int n_frames  = 0;
	int n_writes  = 0;
	bit idle_on   = 1'b1;

	always #1 clk = ~clk;

	dual_channel_frame_average_ema #(
		.SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	dcfa_checker #(
		.SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	// end the run when no request of any channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin : result_sink
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = idle_on ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] val,
			input logic last);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, val};
		s_axis_tlast  <= last;
		s_axis_tuser  <= ch;
		// hold the request until the block takes it
		do @(posedge clk); while (!s_axis_tready);
		n_samples++;
		if (last)
			n_frames++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_writes++;
	endtask

	// drop the sample request, drain all results, let the pipeline go quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return VAL_W'(WEIGHT_ONE);
			2:       return VAL_W'($urandom_range(65537, 20'hFFFFF));
			3:       return VAL_W'($urandom_range(1, 255));
			default: return VAL_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int pick_frame_len();
		case ($urandom_range(0, 4))
			0, 1:    return $urandom_range(1, 16);
			2, 3:    return $urandom_range(56, 72);
			default: return $urandom_range(65, 140);
		endcase
	endfunction

	// mostly the two live channels, some noise on any channel
	task automatic send_frame(input logic [CHAN_W-1:0] act, input logic [CHAN_W-1:0] des,
			input int len);
		logic [CHAN_W-1:0] ch;
		int r;
		for (int i = 0; i < len; i++) begin
			r  = $urandom_range(0, 9);
			ch = (r < 4) ? act : (r < 8) ? des : CHAN_W'($urandom_range(0, 15));
			send_sample(ch, pick_value(), i == len - 1);
		end
	endtask

	initial begin : stimulus
		logic [CHAN_W-1:0] act;
		logic [CHAN_W-1:0] des;
		int rnd_items;
		int phase_end;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: actual on 3, desired on 4
		send_sample(4'd3, 12'd4095, 1'b0);
		send_sample(4'd4, 12'd4095, 1'b0);
		send_sample(4'd5, 12'd4095, 1'b0);
		send_sample(4'd4, 12'd0, 1'b0);
		send_sample(4'd3, 12'd0, 1'b1);
		send_sample(4'd15, 12'd4095, 1'b1);
		send_sample(4'd4, 12'd4095, 1'b1);
		send_sample(4'd0, 12'd0, 1'b1);
		settle();

		// both channel registers equal, upper data bits masked off
		write_reg(CFG_WEIGHT, VAL_W'(WEIGHT_ONE));
		write_reg(CFG_ACT_CHANNEL, 20'hFFFF7);
		write_reg(CFG_DES_CHANNEL, 20'hFFFF7);
		send_sample(4'd7, 12'd4095, 1'b0);
		send_sample(4'd7, 12'd100, 1'b1);
		settle();

		// weight above one, override at full scale
		write_reg(CFG_WEIGHT, 20'hFFFFF);
		write_reg(CFG_ACT_CHANNEL, 20'd0);
		write_reg(CFG_DES_CHANNEL, 20'd15);
		write_reg(CFG_OVR_ENABLE, 20'd1);
		write_reg(CFG_OVR_LEVEL, 20'hFFFFF);
		send_sample(4'd0, 12'd4095, 1'b0);
		send_sample(4'd15, 12'd4095, 1'b1);
		send_sample(4'd15, 12'd1, 1'b1);
		settle();

		// unused index is ignored; enable written with bit 0 clear
		write_reg(CFG_OVR_LEVEL, 20'd0);
		write_reg(CFG_UNUSED, 20'hFFFFF);
		write_reg(CFG_WEIGHT, 20'd0);
		write_reg(CFG_OVR_ENABLE, 20'hFFFFE);
		send_sample(4'd0, 12'd4095, 1'b1);
		settle();
		write_reg(CFG_WEIGHT, 20'd1);
		send_sample(4'd15, 12'd4095, 1'b0);
		send_sample(4'd0, 12'd4095, 1'b1);
		settle();

		rnd_items = 0;
		while (rnd_items < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			act = CHAN_W'($urandom_range(0, 15));
			des = ($urandom_range(0, 5) == 0) ? act : CHAN_W'($urandom_range(0, 15));
			write_reg(CFG_WEIGHT, pick_weight());
			write_reg(CFG_ACT_CHANNEL, {16'($urandom_range(0, 65535)), act});
			write_reg(CFG_DES_CHANNEL, {16'($urandom_range(0, 65535)), des});
			write_reg(CFG_OVR_ENABLE, ($urandom_range(0, 3) == 0) ? 20'd1 : 20'd0);
			write_reg(CFG_OVR_LEVEL, VAL_W'($urandom_range(0, 20'hFFFFF)));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, VAL_W'($urandom_range(0, 20'hFFFFF)));
			phase_end = n_samples + $urandom_range(120, 230);
			while (n_samples < phase_end) begin
				rnd_items -= n_samples;
				send_frame(act, des, pick_frame_len());
				rnd_items += n_samples;
			end
			settle();
		end

		$display("tb: %0d samples in %0d frames, %0d register writes", n_samples, n_frames,
			n_writes);
		$display("tb: weights 0 to above one, shared and noise channels, override, unused index");
		if (fail_count == 0 && pending == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dcfa_pkg.sv
rtl/dcfa_blend.sv
rtl/dual_channel_frame_average_ema.sv
rtl/dcfa_checker.sv
tb/sv/dcfa_checker.sv
tb/sv/tb.sv
